### hw/rtl/ohlc_agg_pkg.sv
// ----------------------------------------------------------------------------
// OHLC aggregator package
// Widths, reset values and the classified item type shared by the front end,
// the item queue and the bar engine.
// ----------------------------------------------------------------------------
package ohlc_agg_pkg;

  // Field widths.
  localparam int TimeW     = 32;
  localparam int PriceW    = 32;
  localparam int VolW      = 32;
  localparam int SumW      = 48;
  localparam int IndexW    = 32;
  localparam int MinutesW  = 11;
  // Widest interval is 2047 minutes of 60 seconds, which needs 17 bits.
  localparam int IntervalW = 17;

  // Reset value of the bar length register, in minutes.
  localparam logic [MinutesW-1:0] BarMinutesReset = 11'd5;

  // Depth of the queue between the front end and the bar engine.
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // A tick after its timestamp has been rounded down to its interval start.
  typedef struct packed {
    logic [TimeW-1:0]  start;
    logic [PriceW-1:0] bid;
    logic [VolW-1:0]   vol;
  } tick_item_t;

endpackage

### hw/rtl/ohlc_agg_front.sv
// ----------------------------------------------------------------------------
// OHLC aggregator front end
// Holds the bar length register, accepts ticks and finds each tick's interval
// start with a bit-serial remainder unit, then hands the item to the queue.
// ----------------------------------------------------------------------------
module ohlc_agg_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 bar_minutes_we,
  input  logic [ohlc_agg_pkg::MinutesW-1:0]    bar_minutes,
  input  logic                                 push,
  output logic                                 full,
  input  logic [ohlc_agg_pkg::TimeW-1:0]       tick_time,
  input  logic [ohlc_agg_pkg::PriceW-1:0]      bid_price,
  input  logic [ohlc_agg_pkg::VolW-1:0]        tick_volume,
  output logic                                 item_valid,
  output ohlc_agg_pkg::tick_item_t             item,
  input  logic                                 item_full
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PUSH
  } state_t;

  localparam int BitCntW = $clog2(ohlc_agg_pkg::TimeW);
  localparam int IW      = ohlc_agg_pkg::IntervalW;
  localparam int MW      = ohlc_agg_pkg::MinutesW;

  state_t                          state;
  logic [MW-1:0]                   minutes_reg;
  logic [ohlc_agg_pkg::TimeW-1:0]  t_reg;
  logic [ohlc_agg_pkg::PriceW-1:0] bid_reg;
  logic [ohlc_agg_pkg::VolW-1:0]   vol_reg;
  logic [ohlc_agg_pkg::TimeW-1:0]  start_reg;
  logic [IW-1:0]                   interval;
  logic [IW-1:0]                   rem;
  logic [BitCntW-1:0]              bit_cnt;

  logic [MW-1:0]                   minutes_eff;
  logic [IW-1:0]                   interval_next;
  logic [IW:0]                     trial;
  logic [IW:0]                     trial_diff;
  logic                            fits;
  logic [IW-1:0]                   rem_next;

  // A zero bar length counts as one minute; the interval is minutes * 60,
  // formed as minutes * 64 - minutes * 4.
  assign minutes_eff   = (minutes_reg == '0) ? MW'(1) : minutes_reg;
  assign interval_next = {minutes_eff, 6'b0} - {4'b0, minutes_eff, 2'b0};

  // One restoring step of the remainder: bring in the next timestamp bit.
  assign trial      = {rem, t_reg[bit_cnt]};
  assign fits       = (trial >= {1'b0, interval});
  assign trial_diff = trial - {1'b0, interval};
  assign rem_next   = fits ? trial_diff[IW-1:0] : trial[IW-1:0];

  // Handshake and the item toward the queue.
  assign full       = (state != ST_IDLE);
  assign item_valid = (state == ST_PUSH);
  assign item.start = start_reg;
  assign item.bid   = bid_reg;
  assign item.vol   = vol_reg;

  // Sequencer, bar length register and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      minutes_reg <= ohlc_agg_pkg::BarMinutesReset;
    end else begin
      if (bar_minutes_we) begin
        minutes_reg <= bar_minutes;
      end
      case (state)
        ST_IDLE: begin
          if (push) begin
            t_reg    <= tick_time;
            bid_reg  <= bid_price;
            vol_reg  <= tick_volume;
            interval <= interval_next;
            rem      <= '0;
            bit_cnt  <= BitCntW'(ohlc_agg_pkg::TimeW - 1);
            state    <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          rem     <= rem_next;
          bit_cnt <= bit_cnt - BitCntW'(1);
          if (bit_cnt == '0) begin
            // The interval start is the timestamp less its remainder.
            start_reg <= t_reg - {{(ohlc_agg_pkg::TimeW - IW){1'b0}}, rem_next};
            state     <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!item_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/ohlc_agg_queue.sv
// ----------------------------------------------------------------------------
// OHLC aggregator item queue
// A short first-in first-out queue of classified ticks that lets the front
// end and the bar engine stall independently.
// ----------------------------------------------------------------------------
module ohlc_agg_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_valid,
  output logic                     wr_full,
  input  ohlc_agg_pkg::tick_item_t wr_item,
  output logic                     rd_valid,
  input  logic                     rd_take,
  output ohlc_agg_pkg::tick_item_t rd_item
);

  localparam int PW = ohlc_agg_pkg::QueuePtrW;
  localparam int CW = ohlc_agg_pkg::QueueCntW;

  ohlc_agg_pkg::tick_item_t entries [ohlc_agg_pkg::QueueDepth];
  logic [PW-1:0]            wr_ptr;
  logic [PW-1:0]            rd_ptr;
  logic [CW-1:0]            count;
  logic                     do_wr;
  logic                     do_rd;

  assign wr_full  = (count == CW'(ohlc_agg_pkg::QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];
  assign do_wr    = wr_valid && !wr_full;
  assign do_rd    = rd_take && rd_valid;

  // Entry storage; written at the tail only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(ohlc_agg_pkg::QueueDepth - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(ohlc_agg_pkg::QueueDepth - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // The fill count never goes past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ohlc_agg_pkg::QueueDepth))
    else $error("queue count above depth");

endmodule

### hw/rtl/ohlc_agg_back.sv
// ----------------------------------------------------------------------------
// OHLC aggregator bar engine
// Keeps the open bar, folds each classified tick into it or finishes it, and
// holds a finished bar in a result register until it is popped.
// ----------------------------------------------------------------------------
module ohlc_agg_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_take,
  input  ohlc_agg_pkg::tick_item_t            item,
  output logic                                empty,
  input  logic                                pop,
  output logic [ohlc_agg_pkg::IndexW-1:0]     bar_index,
  output logic [ohlc_agg_pkg::TimeW-1:0]      bar_start,
  output logic [ohlc_agg_pkg::PriceW-1:0]     open_price,
  output logic [ohlc_agg_pkg::PriceW-1:0]     high_price,
  output logic [ohlc_agg_pkg::PriceW-1:0]     low_price,
  output logic [ohlc_agg_pkg::PriceW-1:0]     close_price,
  output logic [ohlc_agg_pkg::SumW-1:0]       bar_volume
);

  localparam int SW = ohlc_agg_pkg::SumW;
  localparam int VW = ohlc_agg_pkg::VolW;

  // Open bar.
  logic                                bar_held;
  logic [ohlc_agg_pkg::TimeW-1:0]      held_start;
  logic [ohlc_agg_pkg::PriceW-1:0]     held_open;
  logic [ohlc_agg_pkg::PriceW-1:0]     held_high;
  logic [ohlc_agg_pkg::PriceW-1:0]     held_low;
  logic [ohlc_agg_pkg::PriceW-1:0]     held_close;
  logic [SW-1:0]                       held_volume;
  logic [ohlc_agg_pkg::IndexW-1:0]     bars_emitted;
  logic                                res_valid;

  logic                                same_bar;
  logic [SW:0]                         vol_sum;
  logic [SW-1:0]                       vol_next;
  logic [ohlc_agg_pkg::IndexW-1:0]     index_next;

  // An item is taken when the result register is free or being emptied.
  assign item_take = item_valid && (!res_valid || pop);
  assign empty     = !res_valid;
  assign same_bar  = (item.start == held_start);

  // Saturating volume sum and bar counter.
  assign vol_sum    = {1'b0, held_volume} + {{(SW + 1 - VW){1'b0}}, item.vol};
  assign vol_next   = vol_sum[SW] ? {SW{1'b1}} : vol_sum[SW-1:0];
  assign index_next = (bars_emitted == '1) ? bars_emitted
                                           : bars_emitted + ohlc_agg_pkg::IndexW'(1);

  // Bar state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_held     <= 1'b0;
      held_start   <= '0;
      held_open    <= '0;
      held_high    <= '0;
      held_low     <= '0;
      held_close   <= '0;
      held_volume  <= '0;
      bars_emitted <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (item_take) begin
        if (bar_held && same_bar) begin
          // Tick inside the open bar.
          if (item.bid > held_high) begin
            held_high <= item.bid;
          end
          if (item.bid < held_low) begin
            held_low <= item.bid;
          end
          held_close  <= item.bid;
          held_volume <= vol_next;
        end else begin
          // Finish the open bar, if any, then start a new one from the tick.
          if (bar_held) begin
            bars_emitted <= index_next;
            bar_index    <= index_next;
            bar_start    <= held_start;
            open_price   <= held_open;
            high_price   <= held_high;
            low_price    <= held_low;
            close_price  <= held_close;
            bar_volume   <= held_volume;
            res_valid    <= 1'b1;
          end
          bar_held    <= 1'b1;
          held_start  <= item.start;
          held_open   <= item.bid;
          held_high   <= item.bid;
          held_low    <= item.bid;
          held_close  <= item.bid;
          held_volume <= {{(SW - VW){1'b0}}, item.vol};
        end
      end
    end
  end

  // Once a bar is open, one stays open until reset.
  a_bar_stays: assert property (@(posedge clk) disable iff (rst)
    bar_held |=> bar_held)
    else $error("open bar was dropped");

  // The open bar's range always covers its open and close.
  a_range: assert property (@(posedge clk) disable iff (rst)
    bar_held |-> (held_low <= held_open) && (held_open <= held_high) &&
                 (held_low <= held_close) && (held_close <= held_high))
    else $error("open bar range inconsistent");

  // A waiting result always carries a nonzero index and a consistent range.
  a_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (bar_index != '0) && (low_price <= high_price) && bar_held)
    else $error("finished bar inconsistent");

endmodule

### hw/rtl/tick_to_ohlc_bar_aggregator_unit.sv
// ----------------------------------------------------------------------------
// Tick to OHLC bar aggregator
// A bar is finished on the result ports when a tick from another interval
// is taken. The front end takes a new tick only once the last is handed to
// the queue; its remainder unit is bit-serial, one timestamp bit per cycle.
// Reset: synchronous; no bar is open, the bar counter is zero and the bar
// length returns to 5 minutes. The block takes ticks in the cycle after reset.
// ----------------------------------------------------------------------------
module tick_to_ohlc_bar_aggregator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                bar_minutes_we,
  input  logic [ohlc_agg_pkg::MinutesW-1:0]   bar_minutes,
  input  logic                                push,
  output logic                                full,
  input  logic [ohlc_agg_pkg::TimeW-1:0]      tick_time,
  input  logic [ohlc_agg_pkg::PriceW-1:0]     bid_price,
  input  logic [ohlc_agg_pkg::VolW-1:0]       tick_volume,
  output logic                                empty,
  input  logic                                pop,
  output logic [ohlc_agg_pkg::IndexW-1:0]     bar_index,
  output logic [ohlc_agg_pkg::TimeW-1:0]      bar_start,
  output logic [ohlc_agg_pkg::PriceW-1:0]     open_price,
  output logic [ohlc_agg_pkg::PriceW-1:0]     high_price,
  output logic [ohlc_agg_pkg::PriceW-1:0]     low_price,
  output logic [ohlc_agg_pkg::PriceW-1:0]     close_price,
  output logic [ohlc_agg_pkg::SumW-1:0]       bar_volume
);

  logic                     front_valid;
  logic                     front_full;
  ohlc_agg_pkg::tick_item_t front_item;
  logic                     queue_valid;
  logic                     queue_take;
  ohlc_agg_pkg::tick_item_t queue_item;

  // Interval classification.
  ohlc_agg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .bar_minutes_we (bar_minutes_we),
    .bar_minutes    (bar_minutes),
    .push           (push),
    .full           (full),
    .tick_time      (tick_time),
    .bid_price      (bid_price),
    .tick_volume    (tick_volume),
    .item_valid     (front_valid),
    .item           (front_item),
    .item_full      (front_full)
  );

  // Decoupling queue.
  ohlc_agg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_full  (front_full),
    .wr_item  (front_item),
    .rd_valid (queue_valid),
    .rd_take  (queue_take),
    .rd_item  (queue_item)
  );

  // Bar update and result register.
  ohlc_agg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (queue_valid),
    .item_take   (queue_take),
    .item        (queue_item),
    .empty       (empty),
    .pop         (pop),
    .bar_index   (bar_index),
    .bar_start   (bar_start),
    .open_price  (open_price),
    .high_price  (high_price),
    .low_price   (low_price),
    .close_price (close_price),
    .bar_volume  (bar_volume)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick to OHLC bar aggregator testbench
// Sends price ticks through the aggregator under several bar lengths and
// checks every finished bar against an in-bench prediction. The sender and
// the receiver both stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int IndexW   = ohlc_agg_pkg::IndexW;
  localparam int TimeW    = ohlc_agg_pkg::TimeW;
  localparam int PriceW   = ohlc_agg_pkg::PriceW;
  localparam int VolW     = ohlc_agg_pkg::VolW;
  localparam int SumW     = ohlc_agg_pkg::SumW;
  localparam int MinutesW = ohlc_agg_pkg::MinutesW;
  localparam logic [MinutesW-1:0] BarMinutesReset = ohlc_agg_pkg::BarMinutesReset;

  localparam int Latency     = 34;
  localparam int PhaseTicks  = 235;
  localparam int NormalIdle  = 28;

  // One finished bar as it leaves the block.
  typedef struct packed {
    logic [IndexW-1:0] bar_index;
    logic [TimeW-1:0]  bar_start;
    logic [PriceW-1:0] open_price;
    logic [PriceW-1:0] high_price;
    logic [PriceW-1:0] low_price;
    logic [PriceW-1:0] close_price;
    logic [SumW-1:0]   bar_volume;
  } bar_t;

  // Predicts finished bars from accepted ticks and checks them on arrival.
  class bar_scoreboard;
    logic [MinutesW-1:0] minutes;
    bit                  bar_live;
    logic [TimeW-1:0]    live_start;
    logic [PriceW-1:0]   live_open;
    logic [PriceW-1:0]   live_high;
    logic [PriceW-1:0]   live_low;
    logic [PriceW-1:0]   live_close;
    logic [SumW-1:0]     live_volume;
    logic [IndexW-1:0]   bar_count;
    bar_t                expected_bars[$];
    int                  errors;

    function new();
      minutes     = BarMinutesReset;
      bar_live    = 1'b0;
      live_start  = '0;
      live_open   = '0;
      live_high   = '0;
      live_low    = '0;
      live_close  = '0;
      live_volume = '0;
      bar_count   = '0;
      errors      = 0;
    endfunction

    function void set_minutes(logic [MinutesW-1:0] m);
      minutes = m;
    endfunction

    function int pending();
      return expected_bars.size();
    endfunction

    function void open_bar(logic [TimeW-1:0] s, logic [PriceW-1:0] bid,
                           logic [VolW-1:0] vol);
      bar_live    = 1'b1;
      live_start  = s;
      live_open   = bid;
      live_high   = bid;
      live_low    = bid;
      live_close  = bid;
      live_volume = SumW'(vol);
    endfunction

    // Notes an accepted tick; a tick in another interval finishes the bar.
    function void note_tick(logic [TimeW-1:0] t, logic [PriceW-1:0] bid,
                            logic [VolW-1:0] vol);
      logic [31:0]    span;
      logic [TimeW-1:0] first_sec;
      logic [SumW:0]  sum;
      bar_t           done;
      // A zero length counts as one minute.
      span = (minutes == '0) ? 32'd60 : 32'(minutes) * 32'd60;
      first_sec = (t / span) * span;
      if (!bar_live) begin
        open_bar(first_sec, bid, vol);
        return;
      end
      if (first_sec == live_start) begin
        if (bid > live_high) live_high = bid;
        if (bid < live_low) live_low = bid;
        live_close = bid;
        sum = {1'b0, live_volume} + (SumW + 1)'(vol);
        live_volume = sum[SumW] ? '1 : sum[SumW-1:0];
        return;
      end
      if (bar_count != '1) bar_count++;
      done.bar_index   = bar_count;
      done.bar_start   = live_start;
      done.open_price  = live_open;
      done.high_price  = live_high;
      done.low_price   = live_low;
      done.close_price = live_close;
      done.bar_volume  = live_volume;
      expected_bars = {expected_bars, done};
      open_bar(first_sec, bid, vol);
    endfunction

    function void compare(string name, logic [SumW-1:0] want, logic [SumW-1:0] got);
      if (want !== got) begin
        errors++;
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_bar(bar_t got);
      bar_t want;
      if (expected_bars.size() == 0) begin
        errors++;
        $error("bar %0d arrived with none expected", got.bar_index);
        return;
      end
      want = expected_bars.pop_front();
      compare("bar_index", SumW'(want.bar_index), SumW'(got.bar_index));
      compare("bar_start", SumW'(want.bar_start), SumW'(got.bar_start));
      compare("open_price", SumW'(want.open_price), SumW'(got.open_price));
      compare("high_price", SumW'(want.high_price), SumW'(got.high_price));
      compare("low_price", SumW'(want.low_price), SumW'(got.low_price));
      compare("close_price", SumW'(want.close_price), SumW'(got.close_price));
      compare("bar_volume", want.bar_volume, got.bar_volume);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                bar_minutes_we = 1'b0;
  logic [MinutesW-1:0] bar_minutes = '0;
  logic                push = 1'b0;
  logic                full;
  logic [TimeW-1:0]    tick_time = '0;
  logic [PriceW-1:0]   bid_price = '0;
  logic [VolW-1:0]     tick_volume = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [IndexW-1:0]   bar_index;
  logic [TimeW-1:0]    bar_start;
  logic [PriceW-1:0]   open_price;
  logic [PriceW-1:0]   high_price;
  logic [PriceW-1:0]   low_price;
  logic [PriceW-1:0]   close_price;
  logic [SumW-1:0]     bar_volume;

  bar_scoreboard    sb;
  int               idle_pct = NormalIdle;
  logic [TimeW-1:0] walk_time = '0;
  logic [PriceW-1:0] walk_bid = 32'd1_000_000;

  tick_to_ohlc_bar_aggregator_unit dut (
    .clk            (clk),
    .rst            (rst),
    .bar_minutes_we (bar_minutes_we),
    .bar_minutes    (bar_minutes),
    .push           (push),
    .full           (full),
    .tick_time      (tick_time),
    .bid_price      (bid_price),
    .tick_volume    (tick_volume),
    .empty          (empty),
    .pop            (pop),
    .bar_index      (bar_index),
    .bar_start      (bar_start),
    .open_price     (open_price),
    .high_price     (high_price),
    .low_price      (low_price),
    .close_price    (close_price),
    .bar_volume     (bar_volume)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pushes one tick, with random idle cycles ahead of it. An idle cycle
  // counts only when the block could have taken the item.
  task automatic send_tick(input logic [TimeW-1:0] t, input logic [PriceW-1:0] bid,
                           input logic [VolW-1:0] vol);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while (full !== 1'b0);
    end
    push        <= 1'b1;
    tick_time   <= t;
    bid_price   <= bid;
    tick_volume <= vol;
    do @(posedge clk); while (full !== 1'b0);
    sb.note_tick(t, bid, vol);
  endtask

  // Stops sending and waits until every predicted bar has been checked.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3 * Latency) @(posedge clk);
  endtask

  task automatic write_minutes(input logic [MinutesW-1:0] m);
    bar_minutes_we <= 1'b1;
    bar_minutes    <= m;
    @(posedge clk);
    bar_minutes_we <= 1'b0;
    sb.set_minutes(m);
  endtask

  // Edge cases under the reset length of five minutes (300 second bars).
  task automatic directed_ticks();
    send_tick(32'd0, 32'd0, 32'd0);                          // first tick, no bar
    send_tick(32'd299, 32'hFFFF_FFFF, 32'hFFFF_FFFF);        // same bar, top bid
    send_tick(32'd150, 32'd1, 32'hFFFF_FFFF);                // same bar, low bid
    send_tick(32'd300, 32'd1000, 32'd5);                     // next interval
    send_tick(32'd599, 32'd999, 32'd7);
    send_tick(32'd0, 32'd42, 32'd1);                         // back in time
    send_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // top of the clock
    send_tick(32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FF00, 32'h8000_0000, 32'd0);
    send_tick(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_tick(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);  // repeated tick
    send_tick(32'd12_345_678, 32'd1_000_000, 32'd100);
    send_tick(32'd12_345_679, 32'd1_000_000, 32'd100);
  endtask

  // Mostly a time walk that fills bars, with jumps and out of order ticks.
  task automatic random_ticks(input int count);
    logic [31:0]       span;
    logic [PriceW-1:0] bid;
    logic [VolW-1:0]   vol;
    int                pick;
    span = (sb.minutes == '0) ? 32'd60 : 32'(sb.minutes) * 32'd60;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        walk_time = walk_time + 32'($urandom_range(0, span / 3));
      end else if (pick < 86) begin
        walk_time = walk_time + span * 32'($urandom_range(1, 5))
                    + 32'($urandom_range(0, span / 3));
      end else if (pick < 92) begin
        walk_time = walk_time - 32'($urandom_range(0, 2 * span));
      end else if (pick < 97) begin
        walk_time = $urandom;
      end else begin
        walk_time = 32'hFFFF_FFFF - 32'($urandom_range(0, span));
      end

      pick = $urandom_range(0, 99);
      if (pick < 70) walk_bid = walk_bid + 32'($urandom_range(0, 2000)) - 32'd1000;
      else if (pick < 85) walk_bid = $urandom;
      else if (pick < 92) walk_bid = '0;
      else walk_bid = '1;
      bid = walk_bid;

      pick = $urandom_range(0, 99);
      if (pick < 60) vol = 32'($urandom_range(0, 1000));
      else if (pick < 85) vol = $urandom;
      else if (pick < 93) vol = '0;
      else vol = '1;

      send_tick(walk_time, bid, vol);
    end
  endtask

  // Result side: check each accepted bar, then stall at random.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && empty === 1'b0) begin
        sb.check_bar({bar_index, bar_start, open_price, high_price, low_price,
                      close_price, bar_volume});
      end
      pop <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Main sequence: reset, directed ticks, then one random phase per length.
  initial begin
    logic [MinutesW-1:0] lengths [8];
    sb = new();
    lengths[0] = 11'd0;
    lengths[1] = 11'd2047;
    lengths[2] = 11'd1;
    lengths[3] = 11'd1440;
    lengths[4] = 11'd1024;
    lengths[5] = 11'd3;
    lengths[6] = 11'($urandom_range(0, 2047));
    lengths[7] = 11'd5;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    directed_ticks();
    for (int p = 0; p < 8; p++) begin
      drain();
      write_minutes(lengths[p]);
      // One phase runs with no stalls on either side.
      idle_pct = (p == 2) ? 0 : NormalIdle;
      random_ticks(PhaseTicks);
    end
    drain();
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing bars.
  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
